FILE: hdl/fp16n12_pkg.sv
// Shared types and constants for the fp16 planar YUV to NV12 byte packer.
`default_nettype none

package fp16n12_pkg;

    // Field widths of the stream words
    localparam int unsigned HalfW   = 16;
    localparam int unsigned CoordW  = 12;
    localparam int unsigned DimW    = 13;
    localparam int unsigned StrideW = 14;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned OffsetW = 25;
    localparam int unsigned ProdW   = CoordW + StrideW;

    // Configuration register reset values
    localparam logic [DimW-1:0]    DimReset    = 13'd4096;
    localparam logic [StrideW-1:0] StrideReset = 14'd4096;

    // Source plane codes carried in s_tuser
    typedef enum logic [1:0] {
        PLANE_LUMA = 2'd0,
        PLANE_U    = 2'd1,
        PLANE_V    = 2'd2,
        PLANE_NONE = 2'd3
    } plane_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_LUMA_STRIDE   = 2'd2,
        CFG_CHROMA_STRIDE = 2'd3
    } cfg_idx_t;

    // Load enables of the two datapath register stages
    typedef struct packed {
        logic s1;
        logic s2;
    } stage_en_t;

endpackage

`default_nettype wire

FILE: hdl/fp16n12_conv.sv
// Two-stage binary16 to unorm8 converter: scale by 255, round half to even, clamp.
`default_nettype none

module fp16n12_conv (
    input  wire logic                          clk,
    input  wire fp16n12_pkg::stage_en_t        en,
    input  wire logic [fp16n12_pkg::HalfW-1:0] half_sample,
    output logic      [fp16n12_pkg::ByteW-1:0] pixel_byte
);
    import fp16n12_pkg::*;

    typedef enum logic [1:0] {
        K_NUM  = 2'd0,
        K_ZERO = 2'd1,
        K_SAT  = 2'd2
    } kind_t;

    localparam int unsigned PW = 19;   // 2047 * 255 fits in 19 bits

    logic        sgn;
    logic [4:0]  expo;
    logic [9:0]  frac;
    logic [10:0] mant;
    logic [4:0]  expo_eff;
    logic [4:0]  shift_raw;
    kind_t       kind_next;
    logic [4:0]  sh_next;
    logic [PW-1:0] prod_next;

    kind_t       kind_reg;
    logic [4:0]  sh_reg;
    logic [PW-1:0] prod_reg;

    logic [PW:0]   prod_ext;
    logic [4:0]    sh_m1;
    logic [PW:0]   q;
    logic [PW:0]   low_mask;
    logic          rbit;
    logic          sticky;
    logic          inc;
    logic [PW:0]   rounded;
    logic [ByteW-1:0] byte_next;
    logic [ByteW-1:0] byte_reg;

    // Stage 1: field split, special cases, mantissa times 255
    always_comb
    begin
        sgn  = half_sample[15];
        expo = half_sample[14:10];
        frac = half_sample[9:0];
        if (expo == 5'd0)
        begin
            mant     = {1'b0, frac};
            expo_eff = 5'd1;
        end
        else
        begin
            mant     = {1'b1, frac};
            expo_eff = expo;
        end
        if (expo == 5'd31)
            kind_next = (frac != 10'd0 || sgn) ? K_ZERO : K_SAT;
        else if (sgn)
            kind_next = K_ZERO;
        else if (expo_eff >= 5'd25)
            kind_next = K_SAT;
        else
            kind_next = K_NUM;
        // shifts of 20 or more leave nothing of a 19-bit product
        shift_raw = 5'd25 - expo_eff;
        sh_next   = (shift_raw > 5'd20) ? 5'd20 : shift_raw;
        prod_next = PW'(mant) * PW'(8'd255);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            kind_reg <= kind_next;
            sh_reg   <= sh_next;
            prod_reg <= prod_next;
        end
    end

    // Stage 2: shift down, round half to even, saturate
    always_comb
    begin
        prod_ext = {1'b0, prod_reg};
        sh_m1    = sh_reg - 5'd1;
        q        = prod_ext >> sh_reg;
        low_mask = ((PW+1)'(1) << sh_m1) - (PW+1)'(1);
        rbit     = prod_ext[sh_m1];
        sticky   = |(prod_ext & low_mask);
        inc      = rbit & (sticky | q[0]);
        rounded  = q + (PW+1)'(inc);
        case (kind_reg)
            K_ZERO:  byte_next = '0;
            K_SAT:   byte_next = '1;
            default: byte_next = (rounded > (PW+1)'(255)) ? '1 : rounded[ByteW-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
            byte_reg <= byte_next;
    end

    assign pixel_byte = byte_reg;

endmodule

`default_nettype wire

FILE: hdl/fp16n12_addr.sv
// Two-stage byte offset unit: row times stride, then column and V lane added.
`default_nettype none

module fp16n12_addr (
    input  wire logic                             clk,
    input  wire fp16n12_pkg::stage_en_t           en,
    input  wire fp16n12_pkg::plane_t              plane_sel,
    input  wire logic [fp16n12_pkg::CoordW-1:0]   col,
    input  wire logic [fp16n12_pkg::CoordW-1:0]   row,
    input  wire logic [fp16n12_pkg::StrideW-1:0]  luma_stride,
    input  wire logic [fp16n12_pkg::StrideW-1:0]  chroma_stride,
    output logic                                  to_chroma_plane,
    output logic      [fp16n12_pkg::OffsetW-1:0]  byte_offset
);
    import fp16n12_pkg::*;

    logic               chroma;
    logic [CoordW-1:0]  mul_row;
    logic [StrideW-1:0] mul_stride;
    logic [ProdW-1:0]   prod_next;

    logic [ProdW-1:0]   prod_reg;
    logic [CoordW-1:0]  col_reg;
    logic               vlane_reg;
    logic               chroma1_reg;

    logic [OffsetW-1:0] offset_next;
    logic [OffsetW-1:0] offset_reg;
    logic               chroma2_reg;

    // Stage 1: pick row term and stride, one multiply
    always_comb
    begin
        chroma     = (plane_sel != PLANE_LUMA);
        mul_row    = chroma ? {1'b0, row[CoordW-1:1]} : row;
        mul_stride = chroma ? chroma_stride : luma_stride;
        prod_next  = ProdW'(mul_row) * ProdW'(mul_stride);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            prod_reg    <= prod_next;
            col_reg     <= col;
            vlane_reg   <= (plane_sel == PLANE_V);
            chroma1_reg <= chroma;
        end
    end

    // Stage 2: add column and the V interleave step, wrap to offset width
    assign offset_next = OffsetW'(prod_reg + ProdW'(col_reg) + ProdW'(vlane_reg));

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            offset_reg  <= offset_next;
            chroma2_reg <= chroma1_reg;
        end
    end

    assign to_chroma_plane = chroma2_reg;
    assign byte_offset     = offset_reg;

endmodule

`default_nettype wire

FILE: hdl/fp16_planar_yuv_to_nv12_bytes_core.sv
// Top level of the fp16 planar YUV to NV12 byte packer.
//
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: half_sample[15:0] col[27:16] row[39:28]; tuser: plane_sel[1:0]
// m_axis    out  tdata: pixel_byte[7:0] byte_offset[32:8] (zero pad to 40); tuser: to_chroma_plane
// cfg       in   cfg_we, cfg_addr (0 width, 1 height, 2 luma stride, 3 chroma stride), cfg_wdata
//
// One word per cycle when not stalled by m_tready; words pass stage 1, stage 2, output register.
// The depth is set by the two multiplies (mantissa by 255, row by stride) and the
// rounding shift, each followed by a register, then the output register.
// Out-of-frame samples, odd-position chroma and unknown planes enter as bubbles and give no word.
// Each stage moves when it is empty or the next one moves, so a stall loses nothing.
// Reset sets all valid bits low and the frame registers to 4096.
`default_nettype none

module fp16_planar_yuv_to_nv12_bytes_core #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // half_sample[15:0], col[27:16], row[39:28]
    input  wire logic [39:0] s_tdata,
    // plane_sel[1:0]
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pixel_byte[7:0], byte_offset[32:8], zeros above
    output logic [39:0]      m_tdata,
    // to_chroma_plane
    output logic             m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [13:0] cfg_wdata
);
    import fp16n12_pkg::*;

    localparam logic [14:0] MaxWidth = 15'(MAX_WIDTH);

    logic [DimW-1:0]    frame_width_reg;
    logic [DimW-1:0]    frame_height_reg;
    logic [StrideW-1:0] luma_stride_reg;
    logic [StrideW-1:0] chroma_stride_reg;

    logic [HalfW-1:0]   half_sample;
    logic [CoordW-1:0]  col;
    logic [CoordW-1:0]  row;
    plane_t             plane_sel;

    logic [14:0]        w_eff;
    logic [14:0]        h_eff;
    logic               keep;

    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic               rdy1;
    logic               rdy2;
    logic               rdy3;
    stage_en_t          en;

    logic [ByteW-1:0]   byte_s2;
    logic [OffsetW-1:0] offset_s2;
    logic               chroma_s2;

    logic [ByteW-1:0]   byte_reg;
    logic [OffsetW-1:0] offset_reg;
    logic               chroma_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= DimReset;
            frame_height_reg  <= DimReset;
            luma_stride_reg   <= StrideReset;
            chroma_stride_reg <= StrideReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_wdata[DimW-1:0];
                CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_wdata[DimW-1:0];
                CFG_LUMA_STRIDE:   luma_stride_reg   <= cfg_wdata;
                CFG_CHROMA_STRIDE: chroma_stride_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Input word unpacking
    assign half_sample = s_tdata[15:0];
    assign col         = s_tdata[27:16];
    assign row         = s_tdata[39:28];
    assign plane_sel   = plane_t'(s_tuser);

    // Frame window check; out-of-frame samples become bubbles
    always_comb
    begin
        w_eff = (15'(frame_width_reg) > MaxWidth) ? MaxWidth : 15'(frame_width_reg);
        h_eff = 15'(frame_height_reg);
        case (plane_sel) inside
            PLANE_LUMA:
                keep = (15'(col) < w_eff) && (15'(row) < h_eff);
            PLANE_U, PLANE_V:
                keep = !col[0] && !row[0]
                       && (15'(col[CoordW-1:1]) < (w_eff >> 1))
                       && (15'(row[CoordW-1:1]) < (h_eff >> 1));
            default:
                keep = 1'b0;
        endcase
    end

    // Per-stage handshake: a stage loads when empty or when its successor moves
    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign en.s1    = rdy1;
    assign en.s2    = rdy2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= s_tvalid && keep;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    fp16n12_conv u_conv (
        .clk         (clk),
        .en          (en),
        .half_sample (half_sample),
        .pixel_byte  (byte_s2)
    );

    fp16n12_addr u_addr (
        .clk             (clk),
        .en              (en),
        .plane_sel       (plane_sel),
        .col             (col),
        .row             (row),
        .luma_stride     (luma_stride_reg),
        .chroma_stride   (chroma_stride_reg),
        .to_chroma_plane (chroma_s2),
        .byte_offset     (offset_s2)
    );

    // Output register
    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            byte_reg   <= byte_s2;
            offset_reg <= offset_s2;
            chroma_reg <= chroma_s2;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tuser  = chroma_reg;
    assign m_tdata  = {7'd0, offset_reg, byte_reg};

    // An empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v3_reg |-> s_tready)
        else $error("input stalled while output stage empty");

    // Unknown plane never reaches the pipeline
    a_drop_unknown_plane: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == PLANE_NONE) |=> !v1_reg)
        else $error("unknown plane word entered pipeline");

    // A held middle stage keeps its word and its converted byte
    a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !rdy3) |=> (v2_reg && $stable(byte_s2) && $stable(offset_s2)))
        else $error("stage 2 word lost during stall");

    // Output drains when nothing is behind it
    a_output_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && m_tready && !v2_reg) |=> !m_tvalid)
        else $error("output word repeated");

endmodule

`default_nettype wire

FILE: dv/tb_fp16_planar_yuv_to_nv12_bytes_core.sv
// Self-checking testbench for the fp16 planar YUV to NV12 byte packer.
module tb_fp16_planar_yuv_to_nv12_bytes_core;

    import fp16n12_pkg::*;

    localparam int unsigned MaxWidth    = 4096;
    localparam int unsigned DrainCycles = 8;     // pipeline is three deep, with margin
    localparam int unsigned IdleLimit   = 2000;  // cycles with no word moved before giving up
    localparam int unsigned PhaseWords  = 90;
    localparam int unsigned NumPhases   = 5;

    // One expected byte write
    typedef struct packed {
        logic [7:0]  pixel;
        logic        chroma;
        logic [24:0] offset;
    } nv12_write_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    // half_sample[15:0], col[27:16], row[39:28]
    logic [39:0] s_tdata = '0;
    // plane_sel[1:0]
    logic [1:0]  s_tuser = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // pixel_byte[7:0], byte_offset[32:8], zeros above
    logic [39:0] m_tdata;
    // to_chroma_plane
    logic        m_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [13:0] cfg_wdata = '0;

    // Shadow copy of the frame registers
    logic [12:0] frame_w = DimReset;
    logic [12:0] frame_h = DimReset;
    logic [13:0] luma_pitch = StrideReset;
    logic [13:0] chroma_pitch = StrideReset;

    nv12_write_t pending_writes[$];
    bit          calm = 1'b0;
    int          rx_stall = 0;
    int          idle_cycles = 0;
    int          errors = 0;
    int          words_sent = 0;
    int          writes_checked = 0;
    int          luma_writes = 0;
    int          chroma_writes = 0;

    fp16_planar_yuv_to_nv12_bytes_core #(
        .MAX_WIDTH(MaxWidth)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // fp16 to unorm8: x*255, round half to even, clamp; NaN and negatives give 0
    function automatic logic [7:0] half_to_byte(input logic [15:0] half);
        int unsigned mant;
        int unsigned expo;
        int unsigned prod;
        int unsigned shift;
        int unsigned quo;
        int unsigned rem;
        int unsigned tie;
        if (half[14:10] == 5'h1F)
            return (half[9:0] != 0 || half[15]) ? 8'd0 : 8'd255;
        if (half[15])
            return 8'd0;
        expo = (half[14:10] == 0) ? 1 : half[14:10];
        mant = (half[14:10] == 0) ? half[9:0] : {1'b1, half[9:0]};
        if (expo >= 25)
            return 8'd255;
        prod  = mant * 255;
        shift = 25 - expo;
        quo   = prod >> shift;
        rem   = prod & ((32'd1 << shift) - 1);
        tie   = 32'd1 << (shift - 1);
        if (rem > tie || (rem == tie && (quo & 1) != 0))
            quo++;
        return (quo > 255) ? 8'd255 : quo[7:0];
    endfunction

    // Work out the byte write a sample causes; returns 0 when it causes none
    function automatic bit predict_write(input logic [15:0] half, input plane_t plane,
                                         input logic [11:0] col, input logic [11:0] row,
                                         output nv12_write_t wr);
        int unsigned w_eff;
        int unsigned offset;
        wr = '0;
        w_eff = (frame_w > MaxWidth) ? MaxWidth : frame_w;
        case (plane)
            PLANE_LUMA:
            begin
                if (col >= w_eff || row >= frame_h)
                    return 1'b0;
                offset = row * luma_pitch + col;
                wr.chroma = 1'b0;
            end
            PLANE_U, PLANE_V:
            begin
                if (col[0] || row[0])
                    return 1'b0;
                if ((col >> 1) >= (w_eff >> 1) || (row >> 1) >= (frame_h >> 1))
                    return 1'b0;
                offset = (row >> 1) * chroma_pitch + col + ((plane == PLANE_V) ? 1 : 0);
                wr.chroma = 1'b1;
            end
            default:
                return 1'b0;
        endcase
        wr.pixel  = half_to_byte(half);
        wr.offset = offset[24:0];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [13:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_FRAME_WIDTH:   frame_w = value[12:0];
            CFG_FRAME_HEIGHT:  frame_h = value[12:0];
            CFG_LUMA_STRIDE:   luma_pitch = value;
            CFG_CHROMA_STRIDE: chroma_pitch = value;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_frame(input logic [13:0] w, input logic [13:0] h,
                             input logic [13:0] lp, input logic [13:0] cp);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_LUMA_STRIDE, lp);
        write_reg(CFG_CHROMA_STRIDE, cp);
    endtask

    // Stop sending, let every expected write arrive, then let dropped samples flush
    task automatic drain_pipeline();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Send one sample word, with an optional idle burst in front
    task automatic send_word(input logic [15:0] half, input plane_t plane,
                             input logic [11:0] col, input logic [11:0] row);
        nv12_write_t wr;
        int          gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_tdata  <= {row, col, half};
        s_tuser  <= plane;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        words_sent++;
        if (predict_write(half, plane, col, row, wr))
            pending_writes.push_back(wr);
    endtask

    // Random half: raw bits, nominal 0..1, large values, or specials
    function automatic logic [15:0] rand_half();
        logic [15:0] h;
        case ($urandom_range(0, 3))
            0: h = 16'($urandom);
            1: h = 16'($urandom_range(16'h0000, 16'h3C00));
            2: h = {1'b0, 5'($urandom_range(20, 30)), 10'($urandom)};
            default:
            begin
                h = 16'($urandom);
                h[14:10] = ($urandom_range(0, 1) == 0) ? 5'h1F : 5'h00;
            end
        endcase
        return h;
    endfunction

    // Conversion corners, frame corners, an odd chroma column and an unknown plane at reset frame size
    task automatic test_sample_conversion();
        logic [15:0] probes [11] = '{16'h0000, 16'h8000, 16'h3C00, 16'h3800, 16'h37FF,
                                     16'h7C00, 16'hFC00, 16'h7E00, 16'h0001, 16'h7BFF,
                                     16'hBC00};
        foreach (probes[i])
            send_word(probes[i], PLANE_LUMA, 12'(i), 12'd0);
        send_word(16'h3C00, PLANE_LUMA, 12'd4095, 12'd4095);
        send_word(16'h3A00, PLANE_U, 12'd4094, 12'd4094);
        send_word(16'h3400, PLANE_V, 12'd4094, 12'd4094);
        send_word(16'h3C00, PLANE_U, 12'd3, 12'd0);
        send_word(16'h3C00, PLANE_NONE, 12'd0, 12'd0);
        drain_pipeline();
    endtask

    // Odd frame size: edges of the luma frame and the floor-halved chroma grid
    task automatic test_frame_edges();
        set_frame(14'd5, 14'd3, 14'd7, 14'd9);
        send_word(16'h3555, PLANE_LUMA, 12'd4, 12'd2);
        send_word(16'h3555, PLANE_LUMA, 12'd5, 12'd0);
        send_word(16'h3555, PLANE_LUMA, 12'd0, 12'd3);
        send_word(16'h2E66, PLANE_U, 12'd2, 12'd0);
        send_word(16'h2E66, PLANE_U, 12'd4, 12'd0);
        send_word(16'h2E66, PLANE_V, 12'd0, 12'd2);
        drain_pipeline();
    endtask

    // Zero-size frame, then all-ones registers: clamped width and wrapped offsets
    task automatic test_degenerate_frames();
        set_frame(14'd0, 14'd0, 14'd0, 14'd0);
        send_word(16'h3C00, PLANE_LUMA, 12'd0, 12'd0);
        send_word(16'h3C00, PLANE_U, 12'd0, 12'd0);
        drain_pipeline();
        set_frame(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
        send_word(16'h3B00, PLANE_LUMA, 12'd4095, 12'd4095);
        send_word(16'h3B00, PLANE_V, 12'd4094, 12'd4094);
        drain_pipeline();
    endtask

    // Random samples over several frame settings, mostly inside the frame
    task automatic test_random_streams();
        logic [15:0] half;
        plane_t      plane;
        logic [11:0] col;
        logic [11:0] row;
        int unsigned w_eff;
        for (int p = 0; p < NumPhases; p++)
        begin
            case (p)
                0: set_frame(14'd1, 14'd1, 14'd1, 14'd1);
                1: set_frame(14'd4096, 14'd4096, 14'd8192, 14'd8192);
                default:
                    set_frame(14'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096)
                                                              : $urandom_range(1, 48)),
                              14'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096)
                                                              : $urandom_range(1, 48)),
                              14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)));
            endcase
            // final phase runs at full rate on both sides
            if (p == NumPhases - 1)
                calm = 1'b1;
            w_eff = (frame_w > MaxWidth) ? MaxWidth : frame_w;
            for (int n = 0; n < PhaseWords; n++)
            begin
                // hold off once until the pipeline has emptied
                if (p == 2 && n == PhaseWords / 2)
                begin
                    @(negedge clk);
                    s_tvalid <= 1'b0;
                    while (pending_writes.size() != 0)
                        @(posedge clk);
                end
                half  = rand_half();
                plane = ($urandom_range(0, 15) == 0) ? PLANE_NONE
                                                     : plane_t'($urandom_range(0, 2));
                if ($urandom_range(0, 9) < 8)
                begin
                    col = 12'($urandom_range(0, w_eff - 1));
                    row = 12'($urandom_range(0, frame_h - 1));
                    if (plane != PLANE_LUMA && $urandom_range(0, 3) != 0)
                    begin
                        col[0] = 1'b0;
                        row[0] = 1'b0;
                    end
                end
                else
                begin
                    col = 12'($urandom);
                    row = 12'($urandom);
                end
                send_word(half, plane, col, row);
            end
            drain_pipeline();
        end
    endtask

    // Output side back-pressure in random bursts
    always @(negedge clk)
    begin
        if (rx_stall > 0)
        begin
            m_tready <= 1'b0;
            rx_stall--;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            rx_stall = $urandom_range(0, 12);
        end
        else
            m_tready <= 1'b1;
    end

    // Compare each output word with the oldest expected write
    always @(posedge clk)
    begin
        nv12_write_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_writes.size() == 0)
                report_mismatch($sformatf("unexpected word data=%h chroma=%b", m_tdata, m_tuser));
            else
            begin
                want = pending_writes.pop_front();
                if (m_tdata[7:0] !== want.pixel)
                    report_mismatch($sformatf("pixel_byte %0d, want %0d (offset %0d)",
                                              m_tdata[7:0], want.pixel, want.offset));
                if (m_tuser !== want.chroma)
                    report_mismatch($sformatf("to_chroma_plane %b, want %b (offset %0d)",
                                              m_tuser, want.chroma, want.offset));
                if (m_tdata[32:8] !== want.offset)
                    report_mismatch($sformatf("byte_offset %0d, want %0d",
                                              m_tdata[32:8], want.offset));
                if (m_tdata[39:33] !== '0)
                    report_mismatch($sformatf("pad bits %h not zero", m_tdata[39:33]));
                writes_checked++;
                if (want.chroma)
                    chroma_writes++;
                else
                    luma_writes++;
            end
        end
    end

    // Watchdog on cycles where nothing moves
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IdleLimit)
            begin
                $display("watchdog: nothing moved for %0d cycles, %0d writes outstanding",
                         idle_cycles, pending_writes.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_sample_conversion();
        test_frame_edges();
        test_degenerate_frames();
        test_random_streams();
        $display("%0d sample words sent, %0d byte writes checked (%0d luma, %0d chroma)",
                 words_sent, writes_checked, luma_writes, chroma_writes);
        $display("covered NaN, infinities, subnormals, rounding ties, frame edges, "
                 , "empty and oversize frames, offset wrap, stalls on both sides");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
